@@ sv/sm83li_pkg.sv @@
// Package for the SM83 load instruction unit: opcode codes, register file
// indexes, memory access kinds and the result word type. No dependencies.
package sm83li_pkg;

   localparam int unsigned NumRegs  = 7;
   localparam int unsigned FifoDepth = 4;

   // Register file indexes (B, C, D, E, H, L, A).
   localparam logic [2:0] IDX_B = 3'd0;
   localparam logic [2:0] IDX_C = 3'd1;
   localparam logic [2:0] IDX_D = 3'd2;
   localparam logic [2:0] IDX_E = 3'd3;
   localparam logic [2:0] IDX_H = 3'd4;
   localparam logic [2:0] IDX_L = 3'd5;
   localparam logic [2:0] IDX_A = 3'd6;

   // Register field value that selects (HL) instead of a register.
   localparam logic [2:0] FIELD_HL_MEM = 3'd6;
   localparam logic [2:0] FIELD_A      = 3'd7;

   // Input word kinds.
   localparam logic OP_EXECUTE     = 1'b0;
   localparam logic OP_READ_RETURN = 1'b1;

   // Opcodes.
   localparam logic [7:0] OPC_HALT      = 8'h76;
   localparam logic [7:0] OPC_LD_BC_NN  = 8'h01;
   localparam logic [7:0] OPC_LD_DE_NN  = 8'h11;
   localparam logic [7:0] OPC_LD_HL_NN  = 8'h21;
   localparam logic [7:0] OPC_LD_SP_NN  = 8'h31;
   localparam logic [7:0] OPC_ST_NN_SP  = 8'h08;
   localparam logic [7:0] OPC_ST_BC_A   = 8'h02;
   localparam logic [7:0] OPC_ST_DE_A   = 8'h12;
   localparam logic [7:0] OPC_LD_A_BC   = 8'h0A;
   localparam logic [7:0] OPC_LD_A_DE   = 8'h1A;
   localparam logic [7:0] OPC_LDI_ST    = 8'h22;
   localparam logic [7:0] OPC_LDD_ST    = 8'h32;
   localparam logic [7:0] OPC_LDI_LD    = 8'h2A;
   localparam logic [7:0] OPC_LDD_LD    = 8'h3A;
   localparam logic [7:0] OPC_LDH_ST_N  = 8'hE0;
   localparam logic [7:0] OPC_LDH_LD_N  = 8'hF0;
   localparam logic [7:0] OPC_LDH_ST_C  = 8'hE2;
   localparam logic [7:0] OPC_LDH_LD_C  = 8'hF2;
   localparam logic [7:0] OPC_ST_NN_A   = 8'hEA;
   localparam logic [7:0] OPC_LD_A_NN   = 8'hFA;
   localparam logic [7:0] OPC_LD_HL_SPE = 8'hF8;
   localparam logic [7:0] OPC_LD_SP_HL  = 8'hF9;

   localparam logic [7:0] HIGH_PAGE = 8'hFF;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_kind_type;

   typedef struct packed {
      logic        zero;
      logic        sub;
      logic        half;
      logic        carry;
   } flags_type;

   typedef struct packed {
      mem_kind_type mem_kind;
      logic [15:0]  mem_address;
      logic [7:0]   mem_wdata;
      logic [1:0]   imm_used;
      logic [15:0]  dest_value;
      flags_type    flags;
      logic         unknown_op;
      logic         last;
   } rsp_type;

   // Opcode register field to register file index.
   function automatic logic [2:0] field_to_idx(input logic [2:0] field);
      return (field == FIELD_A) ? IDX_A : field;
   endfunction

endpackage

@@ sv/sm83li_ifs.sv @@
// Valid/ready channel interfaces of the SM83 load instruction unit.
// Standalone; the result channel uses the width of the package fields.
interface sm83li_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] opcode;
   logic [7:0] imm_low;
   logic [7:0] imm_high;
   logic [7:0] read_data;

   modport source(output valid, op, opcode, imm_low, imm_high, read_data, input ready);
   modport sink(input valid, op, opcode, imm_low, imm_high, read_data, output ready);
endinterface

interface sm83li_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mem_kind;
   logic [15:0] mem_address;
   logic [7:0]  mem_wdata;
   logic [1:0]  imm_used;
   logic [15:0] dest_value;
   logic        flag_zero;
   logic        flag_sub;
   logic        flag_half;
   logic        flag_carry;
   logic        unknown_op;
   logic        last;

   modport source(output valid, mem_kind, mem_address, mem_wdata, imm_used, dest_value,
                  flag_zero, flag_sub, flag_half, flag_carry, unknown_op, last,
                  input ready);
   modport sink(input valid, mem_kind, mem_address, mem_wdata, imm_used, dest_value,
                flag_zero, flag_sub, flag_half, flag_carry, unknown_op, last,
                output ready);
endinterface

@@ sv/sm83_load_instruction_unit_core.sv @@
// Top level of the SM83 load instruction unit.
// Depends on sm83li_pkg and the channel interfaces in sm83li_ifs.sv.

// Executes the CPU load group on its own B, C, D, E, H, L, A, SP and flag
// registers. While the queue has room, one request word is taken in every
// cycle: decode, the register update and the result are one pass of logic, and
// results go into a four-word output queue, so a request is accepted while
// earlier results wait. A word gives one result, except LD (nn),SP, which gives
// two writes (low byte of SP, then high byte); the queue must have two free
// slots to take a word, so input stalls only when the response side backs up.
// A result is written into the queue when its request is accepted. Memory loads
// emit a read request; the destination is written when a read-return word
// arrives, and a newer load replaces an older pending destination.
module sm83_load_instruction_unit_core (
   input logic clock,
   input logic reset,
   sm83li_req_if.sink   req_chan,
   sm83li_rsp_if.source rsp_chan
);
   import sm83li_pkg::*;

   logic [7:0]  rf_ff [NumRegs];
   logic [7:0]  rf_in [NumRegs];
   logic [15:0] sp_ff, sp_in;
   flags_type   flags_ff, flags_in;
   logic        pend_ff, pend_in;
   logic [2:0]  pdest_ff, pdest_in;

   rsp_type     fifo_ff [FifoDepth];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  cnt_ff;

   rsp_type     res0, res1;
   logic        two_res;
   logic        accept, pop;
   logic [2:0]  push_cnt;

   logic [15:0] hl, bc, de, nn, hl_inc, hl_dec, sp_sum;
   logic [2:0]  src_f, dst_f;
   logic [7:0]  src_val;
   logic [4:0]  half_sum;
   logic [8:0]  low_sum;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = (cnt_ff != 3'd0) && rsp_chan.ready;
   assign req_chan.ready = (cnt_ff <= 3'(FifoDepth - 2));

   assign hl = {rf_ff[IDX_H], rf_ff[IDX_L]};
   assign bc = {rf_ff[IDX_B], rf_ff[IDX_C]};
   assign de = {rf_ff[IDX_D], rf_ff[IDX_E]};
   assign nn = {req_chan.imm_high, req_chan.imm_low};
   assign hl_inc = hl + 16'd1;
   assign hl_dec = hl - 16'd1;
   assign src_f  = req_chan.opcode[2:0];
   assign dst_f  = req_chan.opcode[5:3];
   assign src_val = rf_ff[field_to_idx(src_f)];
   assign half_sum = {1'b0, sp_ff[3:0]} + {1'b0, req_chan.imm_low[3:0]};
   assign low_sum  = {1'b0, sp_ff[7:0]} + {1'b0, req_chan.imm_low};
   assign sp_sum   = sp_ff + {{8{req_chan.imm_low[7]}}, req_chan.imm_low};

   always_comb begin
      rf_in    = rf_ff;
      sp_in    = sp_ff;
      flags_in = flags_ff;
      pend_in  = pend_ff;
      pdest_in = pdest_ff;
      two_res  = 1'b0;
      res0     = '0;
      res0.mem_kind = MEM_NONE;
      res0.last     = 1'b1;

      if (req_chan.op == OP_READ_RETURN) begin
         if (pend_ff) begin
            rf_in[pdest_ff] = req_chan.read_data;
            pend_in         = 1'b0;
            res0.dest_value = {8'd0, req_chan.read_data};
         end
      end else if (req_chan.opcode[7:6] == 2'b01 && req_chan.opcode != OPC_HALT) begin
         if (dst_f == FIELD_HL_MEM) begin
            res0.mem_kind    = MEM_WRITE;
            res0.mem_address = hl;
            res0.mem_wdata   = src_val;
         end else if (src_f == FIELD_HL_MEM) begin
            pend_in          = 1'b1;
            pdest_in         = field_to_idx(dst_f);
            res0.mem_kind    = MEM_READ;
            res0.mem_address = hl;
         end else begin
            rf_in[field_to_idx(dst_f)] = src_val;
            res0.dest_value = {8'd0, src_val};
         end
      end else if (req_chan.opcode[7:6] == 2'b00 && src_f == FIELD_HL_MEM) begin
         res0.imm_used = 2'd1;
         if (dst_f == FIELD_HL_MEM) begin
            res0.mem_kind    = MEM_WRITE;
            res0.mem_address = hl;
            res0.mem_wdata   = req_chan.imm_low;
         end else begin
            rf_in[field_to_idx(dst_f)] = req_chan.imm_low;
            res0.dest_value = {8'd0, req_chan.imm_low};
         end
      end else begin
         unique case (req_chan.opcode) inside
            OPC_LD_BC_NN: begin
               rf_in[IDX_B] = req_chan.imm_high;
               rf_in[IDX_C] = req_chan.imm_low;
               res0.imm_used = 2'd2;
               res0.dest_value = nn;
            end
            OPC_LD_DE_NN: begin
               rf_in[IDX_D] = req_chan.imm_high;
               rf_in[IDX_E] = req_chan.imm_low;
               res0.imm_used = 2'd2;
               res0.dest_value = nn;
            end
            OPC_LD_HL_NN: begin
               rf_in[IDX_H] = req_chan.imm_high;
               rf_in[IDX_L] = req_chan.imm_low;
               res0.imm_used = 2'd2;
               res0.dest_value = nn;
            end
            OPC_LD_SP_NN: begin
               sp_in = nn;
               res0.imm_used = 2'd2;
               res0.dest_value = nn;
            end
            OPC_ST_NN_SP: begin
               two_res          = 1'b1;
               res0.mem_kind    = MEM_WRITE;
               res0.mem_address = nn;
               res0.mem_wdata   = sp_ff[7:0];
               res0.imm_used    = 2'd2;
               res0.last        = 1'b0;
            end
            OPC_ST_BC_A, OPC_ST_DE_A: begin
               res0.mem_kind    = MEM_WRITE;
               res0.mem_address = (req_chan.opcode == OPC_ST_BC_A) ? bc : de;
               res0.mem_wdata   = rf_ff[IDX_A];
            end
            OPC_LD_A_BC, OPC_LD_A_DE: begin
               pend_in          = 1'b1;
               pdest_in         = IDX_A;
               res0.mem_kind    = MEM_READ;
               res0.mem_address = (req_chan.opcode == OPC_LD_A_BC) ? bc : de;
            end
            OPC_LDI_ST, OPC_LDD_ST: begin
               {rf_in[IDX_H], rf_in[IDX_L]} = (req_chan.opcode == OPC_LDI_ST) ? hl_inc : hl_dec;
               res0.mem_kind    = MEM_WRITE;
               res0.mem_address = hl;
               res0.mem_wdata   = rf_ff[IDX_A];
               res0.dest_value  = (req_chan.opcode == OPC_LDI_ST) ? hl_inc : hl_dec;
            end
            OPC_LDI_LD, OPC_LDD_LD: begin
               {rf_in[IDX_H], rf_in[IDX_L]} = (req_chan.opcode == OPC_LDI_LD) ? hl_inc : hl_dec;
               pend_in          = 1'b1;
               pdest_in         = IDX_A;
               res0.mem_kind    = MEM_READ;
               res0.mem_address = hl;
               res0.dest_value  = (req_chan.opcode == OPC_LDI_LD) ? hl_inc : hl_dec;
            end
            OPC_LDH_ST_N: begin
               res0.mem_kind    = MEM_WRITE;
               res0.mem_address = {HIGH_PAGE, req_chan.imm_low};
               res0.mem_wdata   = rf_ff[IDX_A];
               res0.imm_used    = 2'd1;
            end
            OPC_LDH_LD_N: begin
               pend_in          = 1'b1;
               pdest_in         = IDX_A;
               res0.mem_kind    = MEM_READ;
               res0.mem_address = {HIGH_PAGE, req_chan.imm_low};
               res0.imm_used    = 2'd1;
            end
            OPC_LDH_ST_C: begin
               res0.mem_kind    = MEM_WRITE;
               res0.mem_address = {HIGH_PAGE, rf_ff[IDX_C]};
               res0.mem_wdata   = rf_ff[IDX_A];
            end
            OPC_LDH_LD_C: begin
               pend_in          = 1'b1;
               pdest_in         = IDX_A;
               res0.mem_kind    = MEM_READ;
               res0.mem_address = {HIGH_PAGE, rf_ff[IDX_C]};
            end
            OPC_ST_NN_A: begin
               res0.mem_kind    = MEM_WRITE;
               res0.mem_address = nn;
               res0.mem_wdata   = rf_ff[IDX_A];
               res0.imm_used    = 2'd2;
            end
            OPC_LD_A_NN: begin
               pend_in          = 1'b1;
               pdest_in         = IDX_A;
               res0.mem_kind    = MEM_READ;
               res0.mem_address = nn;
               res0.imm_used    = 2'd2;
            end
            OPC_LD_HL_SPE: begin
               // Z and N clear; H and C come from the unsigned low-byte add.
               flags_in = '{zero: 1'b0, sub: 1'b0, half: half_sum[4], carry: low_sum[8]};
               {rf_in[IDX_H], rf_in[IDX_L]} = sp_sum;
               res0.imm_used   = 2'd1;
               res0.dest_value = sp_sum;
            end
            OPC_LD_SP_HL: begin
               sp_in = hl;
               res0.dest_value = hl;
            end
            default: begin
               res0.unknown_op = 1'b1;
            end
         endcase
      end

      res0.flags = flags_in;
      res1 = res0;
      res1.mem_address = nn + 16'd1;
      res1.mem_wdata   = sp_ff[15:8];
      res1.last        = 1'b1;
   end

   assign push_cnt = accept ? (two_res ? 3'd2 : 3'd1) : 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) begin
            rf_ff[i] <= '0;
         end
         sp_ff     <= '0;
         flags_ff  <= '0;
         pend_ff   <= 1'b0;
         pdest_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (accept) begin
            rf_ff    <= rf_in;
            sp_ff    <= sp_in;
            flags_ff <= flags_in;
            pend_ff  <= pend_in;
            pdest_ff <= pdest_in;
         end
         wr_ptr_ff <= wr_ptr_ff + push_cnt[1:0];
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         cnt_ff    <= cnt_ff + push_cnt - {2'b00, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fifo_ff[wr_ptr_ff] <= res0;
         if (two_res) begin
            fifo_ff[wr_ptr_ff + 2'd1] <= res1;
         end
      end
   end

   assign rsp_chan.valid       = (cnt_ff != 3'd0);
   assign rsp_chan.mem_kind    = fifo_ff[rd_ptr_ff].mem_kind;
   assign rsp_chan.mem_address = fifo_ff[rd_ptr_ff].mem_address;
   assign rsp_chan.mem_wdata   = fifo_ff[rd_ptr_ff].mem_wdata;
   assign rsp_chan.imm_used    = fifo_ff[rd_ptr_ff].imm_used;
   assign rsp_chan.dest_value  = fifo_ff[rd_ptr_ff].dest_value;
   assign rsp_chan.flag_zero   = fifo_ff[rd_ptr_ff].flags.zero;
   assign rsp_chan.flag_sub    = fifo_ff[rd_ptr_ff].flags.sub;
   assign rsp_chan.flag_half   = fifo_ff[rd_ptr_ff].flags.half;
   assign rsp_chan.flag_carry  = fifo_ff[rd_ptr_ff].flags.carry;
   assign rsp_chan.unknown_op  = fifo_ff[rd_ptr_ff].unknown_op;
   assign rsp_chan.last        = fifo_ff[rd_ptr_ff].last;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(FifoDepth))
      else $error("result queue count beyond its depth");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.op == OP_READ_RETURN) |=> !pend_ff)
      else $error("read return left a read pending");

   a_load_pends: assert property (@(posedge clock) disable iff (reset)
      (accept && res0.mem_kind == MEM_READ) |=> pend_ff)
      else $error("read request did not mark a pending read");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && !pop) |=> cnt_ff > $past(cnt_ff))
      else $error("accepted word did not enter the result queue");
`endif

endmodule

@@ tb/tb_sm83_load_instruction_unit_core.sv @@
`timescale 1ns / 1ps
// Testbench for sm83_load_instruction_unit_core: directed and random load instructions,
// checked against a predictor kept in this file. Uses sm83li_pkg and sm83li_ifs.sv.
module tb_sm83_load_instruction_unit_core;
   import sm83li_pkg::*;

   localparam int unsigned CycleLimit  = 250000;
   localparam int unsigned DrainCycles = 16;
   localparam int unsigned HoldCycles  = 80;

   localparam logic [7:0] OPC_LD_RR_FIRST = 8'h40;
   localparam logic [7:0] OPC_LD_RR_LAST  = 8'h7F;
   localparam logic [7:0] OPC_NOP         = 8'h00;
   localparam logic [7:0] OPC_RST_38      = 8'hFF;

   localparam logic [7:0] MemOpcodes [14] = '{
      OPC_ST_BC_A, OPC_ST_DE_A, OPC_LD_A_BC, OPC_LD_A_DE, OPC_LDI_ST, OPC_LDD_ST,
      OPC_LDI_LD, OPC_LDD_LD, OPC_LDH_ST_N, OPC_LDH_LD_N, OPC_LDH_ST_C, OPC_LDH_LD_C,
      OPC_ST_NN_A, OPC_LD_A_NN
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sm83li_req_if req_chan();
   sm83li_rsp_if rsp_chan();

   sm83_load_instruction_unit_core uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #6 clock = ~clock;

   // Predicted CPU state.
   logic [7:0]  cpu_regs [NumRegs];
   logic [15:0] cpu_sp;
   flags_type   cpu_flags;
   logic        load_waiting;
   logic [2:0]  load_dest;

   rsp_type     expected_rsp [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          req_idle_enable = 1'b0;
   bit          rsp_idle_enable = 1'b0;
   bit          hold_off_req = 1'b0;

   function automatic logic [2:0] reg_slot(input logic [2:0] field);
      if (field == FIELD_A) return IDX_A;
      return field;
   endfunction

   function automatic logic [15:0] reg_pair(input logic [2:0] high_idx);
      return {cpu_regs[high_idx], cpu_regs[high_idx + 3'd1]};
   endfunction

   task automatic push_result(input mem_kind_type kind, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic [1:0] imm,
                              input logic [15:0] dest, input logic unknown,
                              input logic is_last);
      rsp_type r;
      r.mem_kind    = kind;
      r.mem_address = addr;
      r.mem_wdata   = wdata;
      r.imm_used    = imm;
      r.dest_value  = dest;
      r.flags       = cpu_flags;
      r.unknown_op  = unknown;
      r.last        = is_last;
      expected_rsp.push_back(r);
   endtask

   task automatic start_read(input logic [2:0] idx);
      load_waiting = 1'b1;
      load_dest    = idx;
   endtask

   task automatic predict_load(input logic op, input logic [7:0] opc, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [7:0] rd);
      logic [15:0] nn, hl, new_hl, ext, sum;
      logic [2:0]  src, dst, pair_hi;
      logic [4:0]  nib_sum;
      logic [8:0]  byte_sum;
      nn      = {hi, lo};
      hl      = reg_pair(IDX_H);
      src     = opc[2:0];
      dst     = opc[5:3];
      pair_hi = {opc[5:4], 1'b0};
      new_hl  = (opc == OPC_LDI_ST || opc == OPC_LDI_LD) ? hl + 16'd1 : hl - 16'd1;
      if (op == OP_READ_RETURN) begin
         if (load_waiting) begin
            cpu_regs[load_dest] = rd;
            load_waiting = 1'b0;
            push_result(MEM_NONE, 16'h0, 8'h0, 2'd0, {8'h00, rd}, 1'b0, 1'b1);
         end else begin
            push_result(MEM_NONE, 16'h0, 8'h0, 2'd0, 16'h0, 1'b0, 1'b1);
         end
      end else if (opc >= OPC_LD_RR_FIRST && opc <= OPC_LD_RR_LAST && opc != OPC_HALT) begin
         if (dst == FIELD_HL_MEM) begin
            push_result(MEM_WRITE, hl, cpu_regs[reg_slot(src)], 2'd0, 16'h0, 1'b0, 1'b1);
         end else if (src == FIELD_HL_MEM) begin
            start_read(reg_slot(dst));
            push_result(MEM_READ, hl, 8'h0, 2'd0, 16'h0, 1'b0, 1'b1);
         end else begin
            cpu_regs[reg_slot(dst)] = cpu_regs[reg_slot(src)];
            push_result(MEM_NONE, 16'h0, 8'h0, 2'd0, {8'h00, cpu_regs[reg_slot(dst)]},
                        1'b0, 1'b1);
         end
      end else if (opc < OPC_LD_RR_FIRST && src == FIELD_HL_MEM) begin
         if (dst == FIELD_HL_MEM) begin
            push_result(MEM_WRITE, hl, lo, 2'd1, 16'h0, 1'b0, 1'b1);
         end else begin
            cpu_regs[reg_slot(dst)] = lo;
            push_result(MEM_NONE, 16'h0, 8'h0, 2'd1, {8'h00, lo}, 1'b0, 1'b1);
         end
      end else begin
         case (opc)
            OPC_LD_BC_NN, OPC_LD_DE_NN, OPC_LD_HL_NN: begin
               cpu_regs[pair_hi]        = hi;
               cpu_regs[pair_hi + 3'd1] = lo;
               push_result(MEM_NONE, 16'h0, 8'h0, 2'd2, nn, 1'b0, 1'b1);
            end
            OPC_LD_SP_NN: begin
               cpu_sp = nn;
               push_result(MEM_NONE, 16'h0, 8'h0, 2'd2, nn, 1'b0, 1'b1);
            end
            OPC_ST_NN_SP: begin
               push_result(MEM_WRITE, nn, cpu_sp[7:0], 2'd2, 16'h0, 1'b0, 1'b0);
               push_result(MEM_WRITE, nn + 16'd1, cpu_sp[15:8], 2'd2, 16'h0, 1'b0, 1'b1);
            end
            OPC_ST_BC_A, OPC_ST_DE_A: begin
               push_result(MEM_WRITE, reg_pair(pair_hi), cpu_regs[IDX_A], 2'd0, 16'h0,
                           1'b0, 1'b1);
            end
            OPC_LD_A_BC, OPC_LD_A_DE: begin
               start_read(IDX_A);
               push_result(MEM_READ, reg_pair(pair_hi), 8'h0, 2'd0, 16'h0, 1'b0, 1'b1);
            end
            OPC_LDI_ST, OPC_LDD_ST: begin
               cpu_regs[IDX_H] = new_hl[15:8];
               cpu_regs[IDX_L] = new_hl[7:0];
               push_result(MEM_WRITE, hl, cpu_regs[IDX_A], 2'd0, new_hl, 1'b0, 1'b1);
            end
            OPC_LDI_LD, OPC_LDD_LD: begin
               // The read goes to HL as it was before the step.
               cpu_regs[IDX_H] = new_hl[15:8];
               cpu_regs[IDX_L] = new_hl[7:0];
               start_read(IDX_A);
               push_result(MEM_READ, hl, 8'h0, 2'd0, new_hl, 1'b0, 1'b1);
            end
            OPC_LDH_ST_N: begin
               push_result(MEM_WRITE, {HIGH_PAGE, lo}, cpu_regs[IDX_A], 2'd1, 16'h0,
                           1'b0, 1'b1);
            end
            OPC_LDH_LD_N: begin
               start_read(IDX_A);
               push_result(MEM_READ, {HIGH_PAGE, lo}, 8'h0, 2'd1, 16'h0, 1'b0, 1'b1);
            end
            OPC_LDH_ST_C: begin
               push_result(MEM_WRITE, {HIGH_PAGE, cpu_regs[IDX_C]}, cpu_regs[IDX_A], 2'd0,
                           16'h0, 1'b0, 1'b1);
            end
            OPC_LDH_LD_C: begin
               start_read(IDX_A);
               push_result(MEM_READ, {HIGH_PAGE, cpu_regs[IDX_C]}, 8'h0, 2'd0, 16'h0,
                           1'b0, 1'b1);
            end
            OPC_ST_NN_A: begin
               push_result(MEM_WRITE, nn, cpu_regs[IDX_A], 2'd2, 16'h0, 1'b0, 1'b1);
            end
            OPC_LD_A_NN: begin
               start_read(IDX_A);
               push_result(MEM_READ, nn, 8'h0, 2'd2, 16'h0, 1'b0, 1'b1);
            end
            OPC_LD_HL_SPE: begin
               // Half and carry come from the unsigned low-byte addition.
               ext      = {{8{lo[7]}}, lo};
               sum      = cpu_sp + ext;
               nib_sum  = {1'b0, cpu_sp[3:0]} + {1'b0, lo[3:0]};
               byte_sum = {1'b0, cpu_sp[7:0]} + {1'b0, lo};
               cpu_flags.zero  = 1'b0;
               cpu_flags.sub   = 1'b0;
               cpu_flags.half  = nib_sum[4];
               cpu_flags.carry = byte_sum[8];
               cpu_regs[IDX_H] = sum[15:8];
               cpu_regs[IDX_L] = sum[7:0];
               push_result(MEM_NONE, 16'h0, 8'h0, 2'd1, sum, 1'b0, 1'b1);
            end
            OPC_LD_SP_HL: begin
               cpu_sp = hl;
               push_result(MEM_NONE, 16'h0, 8'h0, 2'd0, hl, 1'b0, 1'b1);
            end
            default: begin
               push_result(MEM_NONE, 16'h0, 8'h0, 2'd0, 16'h0, 1'b1, 1'b1);
            end
         endcase
      end
   endtask

   // Offers one word, waits for it to be taken, and records what it should produce.
   task automatic send_word(input logic op, input logic [7:0] opc, input logic [7:0] lo,
                            input logic [7:0] hi, input logic [7:0] rd);
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.opcode    <= opc;
      req_chan.imm_low   <= lo;
      req_chan.imm_high  <= hi;
      req_chan.read_data <= rd;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_load(op, opc, lo, hi, rd);
      if (req_idle_enable && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic execute_word(input logic [7:0] opc, input logic [7:0] lo,
                               input logic [7:0] hi);
      send_word(OP_EXECUTE, opc, lo, hi, 8'($urandom));
   endtask

   task automatic return_read(input logic [7:0] rd);
      send_word(OP_READ_RETURN, 8'($urandom), 8'($urandom), 8'($urandom), rd);
   endtask

   function automatic logic [7:0] pick_load_opcode();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return OPC_LD_RR_FIRST + 8'($urandom_range(0, 63));
      if (pick < 55) return {2'b00, 3'($urandom_range(0, 7)), FIELD_HL_MEM};
      if (pick < 63) return {2'b00, 2'($urandom_range(0, 3)), 4'h1};
      if (pick < 85) return MemOpcodes[$urandom_range(0, 13)];
      if (pick < 88) return OPC_ST_NN_SP;
      if (pick < 93) return pick[0] ? OPC_LD_HL_SPE : OPC_LD_SP_HL;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly load-group instructions, with data returned for most pending reads
   // and an occasional stray return word.
   task automatic random_word();
      if (load_waiting && $urandom_range(0, 2) != 0)
         return_read(8'($urandom));
      else if ($urandom_range(0, 24) == 0)
         return_read(8'($urandom));
      else
         execute_word(pick_load_opcode(), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_immediate_loads();
      execute_word(OPC_LD_BC_NN, 8'hFF, 8'hFF);
      execute_word(OPC_LD_DE_NN, 8'h00, 8'h00);
      execute_word(OPC_LD_SP_NN, 8'hFF, 8'hFF);
      execute_word({2'b00, FIELD_A, FIELD_HL_MEM}, 8'hFF, 8'h00);
      execute_word({2'b00, FIELD_HL_MEM, FIELD_HL_MEM}, 8'h00, 8'hFF);
      execute_word(OPC_LD_HL_NN, 8'hFF, 8'hFF);
   endtask

   task automatic test_register_moves();
      execute_word(OPC_LD_RR_FIRST, 8'h00, 8'h00);
      execute_word(OPC_LD_RR_LAST, 8'hFF, 8'hFF);
   endtask

   task automatic test_memory_stores();
      // HL starts at FFFF, so the increment and the decrement both wrap.
      execute_word(OPC_LDI_ST, 8'h00, 8'h00);
      execute_word(OPC_LDD_ST, 8'h00, 8'h00);
      execute_word(OPC_ST_BC_A, 8'h00, 8'h00);
      execute_word(OPC_ST_DE_A, 8'h00, 8'h00);
      execute_word(OPC_LDH_ST_N, 8'hFF, 8'h00);
      execute_word(OPC_LDH_ST_C, 8'h00, 8'h00);
      execute_word(OPC_ST_NN_A, 8'h00, 8'h00);
      execute_word({2'b01, FIELD_HL_MEM, IDX_B}, 8'h00, 8'h00);
   endtask

   task automatic test_stack_pointer();
      // The second write of LD (nn),SP wraps to address zero.
      execute_word(OPC_ST_NN_SP, 8'hFF, 8'hFF);
      execute_word(OPC_LD_HL_SPE, 8'h01, 8'h00);
      execute_word(OPC_LD_HL_SPE, 8'h80, 8'h00);
      execute_word(OPC_LD_SP_HL, 8'h00, 8'h00);
      execute_word(OPC_LD_HL_SPE, 8'h00, 8'h00);
   endtask

   task automatic test_memory_loads();
      return_read(8'h5A);
      execute_word({2'b01, IDX_B, FIELD_HL_MEM}, 8'h00, 8'h00);
      // A newer load takes over the pending destination.
      execute_word(OPC_LD_A_NN, 8'hFF, 8'hFF);
      return_read(8'h00);
      execute_word(OPC_LDI_LD, 8'h00, 8'h00);
      execute_word(OPC_LDD_LD, 8'h00, 8'h00);
      execute_word(OPC_LDH_LD_N, 8'h00, 8'h00);
      execute_word(OPC_LDH_LD_C, 8'h00, 8'h00);
      execute_word(OPC_LD_A_BC, 8'h00, 8'h00);
      execute_word(OPC_LD_A_DE, 8'h00, 8'h00);
      return_read(8'hFF);
   endtask

   task automatic test_unknown_opcodes();
      execute_word(OPC_HALT, 8'h00, 8'h00);
      execute_word(OPC_RST_38, 8'hFF, 8'hFF);
      execute_word(OPC_NOP, 8'h00, 8'h00);
   endtask

   task automatic test_random_programs(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) random_word();
   endtask

   task automatic test_backpressure();
      int unsigned i;
      hold_off_req = 1'b1;
      for (i = 0; i < 40; i++) random_word();
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.mem_kind    = mem_kind_type'(rsp_chan.mem_kind);
         got.mem_address = rsp_chan.mem_address;
         got.mem_wdata   = rsp_chan.mem_wdata;
         got.imm_used    = rsp_chan.imm_used;
         got.dest_value  = rsp_chan.dest_value;
         got.flags.zero  = rsp_chan.flag_zero;
         got.flags.sub   = rsp_chan.flag_sub;
         got.flags.half  = rsp_chan.flag_half;
         got.flags.carry = rsp_chan.flag_carry;
         got.unknown_op  = rsp_chan.unknown_op;
         got.last        = rsp_chan.last;
         if (expected_rsp.size() == 0) begin
            error_count++;
            $display("%0t: result word with none expected, actual %p", $time, got);
         end else begin
            want = expected_rsp.pop_front();
            check_field("mem_kind", 16'(want.mem_kind), 16'(got.mem_kind));
            check_field("mem_address", want.mem_address, got.mem_address);
            check_field("mem_wdata", 16'(want.mem_wdata), 16'(got.mem_wdata));
            check_field("imm_used", 16'(want.imm_used), 16'(got.imm_used));
            check_field("dest_value", want.dest_value, got.dest_value);
            check_field("flag_zero", 16'(want.flags.zero), 16'(got.flags.zero));
            check_field("flag_sub", 16'(want.flags.sub), 16'(got.flags.sub));
            check_field("flag_half", 16'(want.flags.half), 16'(got.flags.half));
            check_field("flag_carry", 16'(want.flags.carry), 16'(got.flags.carry));
            check_field("unknown_op", 16'(want.unknown_op), 16'(got.unknown_op));
            check_field("last", 16'(want.last), 16'(got.last));
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int unsigned hold_count;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            for (hold_count = 0; hold_count < HoldCycles; hold_count++) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (rsp_idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.op        = OP_EXECUTE;
      req_chan.opcode    = 8'h00;
      req_chan.imm_low   = 8'h00;
      req_chan.imm_high  = 8'h00;
      req_chan.read_data = 8'h00;
      for (int i = 0; i < NumRegs; i++) cpu_regs[i] = 8'h00;
      cpu_sp       = 16'h0;
      cpu_flags    = '0;
      load_waiting = 1'b0;
      load_dest    = 3'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      test_immediate_loads();
      test_register_moves();
      test_memory_stores();
      test_stack_pointer();
      test_memory_loads();
      test_unknown_opcodes();
      test_random_programs(1200);
      req_idle_enable = 1'b0;
      test_backpressure();
      rsp_idle_enable = 1'b0;
      test_random_programs(450);
      req_chan.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
